/* hdl/hbt_pkg.sv */
// hbt_pkg: shared types, constants and helpers for heading_to_boundary_target
// no dependencies; imported by hbt_div and heading_to_boundary_target

package hbt_pkg;

	// default parameter values
	localparam int WARMUP_SAMPLES_DEF = 5;
	localparam int ANGLE_WIDTH_DEF    = 16;

	// fixed widths of the datapath
	localparam int MAP_W  = 12;
	localparam int MUL_W  = 34;   // shared multiplier operand width (signed)
	localparam int PROD_W = 2 * MUL_W;
	localparam int NUM_W  = 49;   // signed dividend / result width
	localparam int DEN_W  = 38;   // signed divisor width
	localparam int DIV_NW = NUM_W - 1;  // dividend magnitude bits
	localparam int DIV_DW = DEN_W - 1;  // divisor magnitude bits
	localparam int MC_W   = 44;   // map size times sine or cosine

	// angle and fixed point constants
	localparam int HALF_TURN   = 23040;
	localparam int FULL_TURN   = 46080;
	localparam int BETA_UNITS  = 3144;
	localparam int GAMMA_UNITS = 13729;
	localparam int FLOOR_CELLS = 100;
	localparam int MAP_RESET   = 1000;

	localparam logic signed [MUL_W-1:0] ONE_Q = 34'sd1073741824;
	localparam logic signed [MUL_W-1:0] PI_Q  = 34'sd3373259426;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SECT,
		S_MRAD,
		S_SQ,
		S_LMUL,
		S_SFIN,
		S_MS,
		S_MC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FIN
	} hbt_state_t;

	typedef enum logic [1:0] {
		DT_RAD,
		DT_COEF,
		DT_FINAL
	} div_tag_t;

	typedef enum logic [1:0] {
		SEC_TOP,
		SEC_RIGHT,
		SEC_LEFT,
		SEC_BOTTOM
	} sector_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	// series coefficient 2k(2k+1) for sine, (2k-1)2k for cosine
	function automatic logic [8:0] hbt_coef(input logic is_cos, input logic [3:0] k);
		logic [5:0] tk;
		logic [5:0] other;
		logic [11:0] p;
		tk = {1'b0, k, 1'b0};
		other = is_cos ? (tk - 6'd1) : (tk + 6'd1);
		p = 12'(tk) * 12'(other);
		return p[8:0];
	endfunction

endpackage

/* hdl/hbt_div.sv */
// hbt_div: unsigned restoring divider, one quotient bit per cycle
// depends on hbt_pkg for the request struct

module hbt_div
	import hbt_pkg::*;
#(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          fits;

	// one trial subtraction per cycle
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload of the iteration
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hdl/heading_to_boundary_target.sv */
// heading_to_boundary_target: yaw sample to map boundary target point
// depends on hbt_pkg and hbt_div
//
// channel   direction  handshake             payload
// in        input      in_valid/in_ready     heading_deg
// out       output     out_valid/out_ready   target_x, target_y
// cfg       input      map_size_we           map_size_data
//
// a warmup beat or a bottom-centre result does not use the divider; a sector result takes
// 18 passes through the 48-step shared divider (angle
// scale, sixteen series terms, final ratio) plus one shared 34x34 multiplier step each stage.
// reset clears the warmup count, reference heading, map size (1000) and output valid.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register while the next beat is taken, and the sequencer holds if it is full.

module heading_to_boundary_target
	import hbt_pkg::*;
#(
	parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF,
	parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ANGLE_WIDTH-1:0] heading_deg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [MAP_W-1:0]              target_x,
	output logic [MAP_W-1:0]              target_y,
	input  logic                          map_size_we,
	input  logic [MAP_W-1:0]              map_size_data
);

	localparam int AL_W = (ANGLE_WIDTH + 2 > 18) ? ANGLE_WIDTH + 2 : 18;
	localparam logic signed [AL_W-1:0] HALF_A  = AL_W'(HALF_TURN);
	localparam logic signed [AL_W-1:0] FULL_A  = AL_W'(FULL_TURN);
	localparam logic signed [AL_W-1:0] BETA_A  = AL_W'(BETA_UNITS);
	localparam logic signed [AL_W-1:0] GAMMA_A = AL_W'(GAMMA_UNITS);

	// truncate a Q30 product toward zero
	function automatic logic signed [MUL_W-1:0] mul_q(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] b;
		b = p + (p[PROD_W-1] ? PROD_W'(64'sd1073741823) : PROD_W'(0));
		b = b >>> 30;
		return b[MUL_W-1:0];
	endfunction

	// raise to the floor, then cap at the map size
	function automatic logic [MAP_W-1:0] finish(input logic signed [NUM_W-1:0] v,
		input logic [MAP_W-1:0] m);
		logic signed [NUM_W-1:0] r;
		r = v;
		if (r < NUM_W'(FLOOR_CELLS))
			r = NUM_W'(FLOOR_CELLS);
		if (r > $signed({{(NUM_W-MAP_W){1'b0}}, m}))
			r = $signed({{(NUM_W-MAP_W){1'b0}}, m});
		return r[MAP_W-1:0];
	endfunction

	hbt_state_t state_q, state_d;
	div_tag_t   tag_q;
	sector_t    sec_q;

	logic [MAP_W-1:0]             map_q;
	logic [2:0]                   warm_q;
	logic signed [ANGLE_WIDTH-1:0] ref_q;
	logic signed [AL_W-1:0]       alpha_q;
	logic signed [MUL_W-1:0]      rad_q, x2_q, t_q, s_q;
	logic signed [MC_W-1:0]       ms_q;
	logic [3:0]                   k_q;
	logic                         is_cos_q;
	logic signed [NUM_W-1:0]      dnum_q, x_res_q, y_res_q;
	logic signed [DEN_W-1:0]      dden_q;
	logic                         out_valid_q;
	logic [MAP_W-1:0]             tx_q, ty_q;

	// sign-extended heading and reference, wrapped error
	logic signed [AL_W-1:0] h, r, alpha;
	assign h = AL_W'(heading_deg);
	assign r = AL_W'(ref_q);

	always_comb begin
		if ((h > 0 && r > 0) || (h < 0 && r < 0))
			alpha = r - h;
		else if (h - r > HALF_A)
			alpha = FULL_A + r - h;
		else if (r - h > HALF_A)
			alpha = r - h - FULL_A;
		else
			alpha = r - h;
	end

	// constant fractions of the map size by reciprocal multiply
	logic [24:0] m_div10;
	logic [32:0] m9_div10;
	logic [17:0] m39;
	logic [31:0] m39_div40;
	assign m_div10   = (25'(map_q) * 25'd6554) >> 16;
	assign m9_div10  = (33'(map_q) * 33'd9 * 33'd52429) >> 19;
	assign m39       = 18'(map_q) * 18'd39;
	assign m39_div40 = (32'(m39[17:3]) * 32'd52429) >> 18;

	// shared multiplier with operand select
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [MUL_W-1:0]  m_s;
	assign m_s = $signed({{(MUL_W-MAP_W){1'b0}}, map_q});

	always_comb begin
		mul_a = rad_q;
		mul_b = t_q;
		case (state_q)
			S_MRAD: begin
				mul_a = MUL_W'(alpha_q);
				mul_b = PI_Q;
			end
			S_SQ: begin
				mul_a = rad_q;
				mul_b = rad_q;
			end
			S_LMUL: begin
				mul_a = x2_q;
				mul_b = t_q;
			end
			S_SFIN: begin
				mul_a = rad_q;
				mul_b = t_q;
			end
			S_MS: begin
				mul_a = m_s;
				mul_b = s_q;
			end
			S_MC: begin
				mul_a = m_s;
				mul_b = t_q;
			end
			default: begin
				mul_a = rad_q;
				mul_b = t_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// final ratio operands
	logic signed [NUM_W-1:0] ms_w, mc_w, fin_num;
	logic signed [DEN_W-1:0] fin_den;
	assign ms_w = NUM_W'(ms_q);
	assign mc_w = NUM_W'($signed(mul_p[MC_W-1:0]));

	always_comb begin
		case (sec_q)
			SEC_TOP: begin
				fin_num = ms_w * 49'sd35 + mc_w * 49'sd20;
				fin_den = DEN_W'(t_q) * 38'sd40;
			end
			SEC_RIGHT: begin
				fin_num = mc_w * 49'sd16 + ms_w * 49'sd4;
				fin_den = DEN_W'(s_q) * 38'sd40;
			end
			SEC_LEFT: begin
				fin_num = mc_w * 49'sd16 - ms_w * 49'sd4;
				fin_den = -(DEN_W'(s_q) * 38'sd40);
			end
			default: begin
				fin_num = '0;
				fin_den = '0;
			end
		endcase
	end

	// divider: magnitudes in, sign restored on the way out
	div_req_t          div_req;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;
	logic signed [NUM_W-1:0] num_abs;
	logic signed [DEN_W-1:0] den_abs;
	logic signed [NUM_W-1:0] q_s;
	logic                    q_neg;

	assign num_abs = dnum_q[NUM_W-1] ? -dnum_q : dnum_q;
	assign den_abs = dden_q[DEN_W-1] ? -dden_q : dden_q;
	assign q_neg   = dnum_q[NUM_W-1] ^ dden_q[DEN_W-1];
	assign div_req.start = (state_q == S_DIV_GO);
	assign div_req.num   = num_abs[DIV_NW-1:0];
	assign div_req.den   = den_abs[DIV_DW-1:0];

	always_comb begin
		if (dden_q == '0)
			q_s = '0;
		else if (q_neg)
			q_s = -$signed({1'b0, div_quo});
		else
			q_s = $signed({1'b0, div_quo});
	end

	hbt_div #(
		.NW (DIV_NW),
		.DW (DIV_DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && warm_q >= 3'(WARMUP_SAMPLES))
					state_d = S_SECT;
			end
			S_SECT: begin
				if (alpha_q >= -BETA_A && alpha_q <= GAMMA_A)
					state_d = S_MRAD;
				else if (alpha_q < -BETA_A && alpha_q >= -GAMMA_A)
					state_d = S_MRAD;
				else
					state_d = S_FIN;
			end
			S_MRAD:   state_d = S_DIV_GO;
			S_SQ:     state_d = S_LMUL;
			S_LMUL:   state_d = S_DIV_GO;
			S_SFIN:   state_d = S_LMUL;
			S_MS:     state_d = S_MC;
			S_MC:     state_d = S_DIV_GO;
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_done) begin
					case (tag_q)
						DT_RAD:  state_d = S_SQ;
						DT_COEF: begin
							if (k_q != 4'd1)
								state_d = S_LMUL;
							else if (!is_cos_q)
								state_d = S_SFIN;
							else
								state_d = S_MS;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, configuration and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			map_q       <= MAP_W'(MAP_RESET);
			warm_q      <= '0;
			ref_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (map_size_we)
				map_q <= map_size_data;
			if (state_q == S_IDLE && in_valid && warm_q < 3'(WARMUP_SAMPLES)) begin
				ref_q  <= heading_deg;
				warm_q <= warm_q + 3'd1;
			end
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: alpha_q <= alpha;
			S_SECT: begin
				if (alpha_q >= -BETA_A && alpha_q <= BETA_A) begin
					sec_q   <= SEC_TOP;
					y_res_q <= NUM_W'(m39_div40[MAP_W-1:0]);
				end else if (alpha_q > BETA_A && alpha_q <= GAMMA_A) begin
					sec_q   <= SEC_RIGHT;
					x_res_q <= NUM_W'(m9_div10[MAP_W-1:0]);
				end else if (alpha_q < -BETA_A && alpha_q >= -GAMMA_A) begin
					sec_q   <= SEC_LEFT;
					x_res_q <= NUM_W'(m_div10[MAP_W-1:0]);
				end else begin
					sec_q   <= SEC_BOTTOM;
					x_res_q <= NUM_W'(map_q >> 1);
					y_res_q <= NUM_W'(m_div10[MAP_W-1:0]);
				end
			end
			S_MRAD: begin
				dnum_q <= mul_p[NUM_W-1:0];
				dden_q <= DEN_W'(HALF_TURN);
				tag_q  <= DT_RAD;
			end
			S_SQ: begin
				x2_q     <= mul_q(mul_p);
				t_q      <= ONE_Q;
				k_q      <= 4'd8;
				is_cos_q <= 1'b0;
			end
			S_LMUL: begin
				dnum_q <= NUM_W'(mul_q(mul_p));
				dden_q <= DEN_W'(hbt_coef(is_cos_q, k_q));
				tag_q  <= DT_COEF;
			end
			S_SFIN: begin
				s_q      <= mul_q(mul_p);
				t_q      <= ONE_Q;
				k_q      <= 4'd8;
				is_cos_q <= 1'b1;
			end
			S_MS: ms_q <= mul_p[MC_W-1:0];
			S_MC: begin
				dnum_q <= fin_num;
				dden_q <= fin_den;
				tag_q  <= DT_FINAL;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					case (tag_q)
						DT_RAD: rad_q <= q_s[MUL_W-1:0];
						DT_COEF: begin
							t_q <= ONE_Q - q_s[MUL_W-1:0];
							k_q <= k_q - 4'd1;
						end
						default: begin
							if (sec_q == SEC_TOP)
								x_res_q <= q_s;
							else
								y_res_q <= q_s;
						end
					endcase
				end
			end
			S_FIN: begin
				if (out_free) begin
					tx_q <= finish(x_res_q, map_q);
					ty_q <= finish(y_res_q, map_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign target_x  = tx_q;
	assign target_y  = ty_q;

endmodule
